@@ sv/pal_pkg.sv @@
`timescale 1ns / 1ps

package pal_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 9;
   localparam int LENGTH_W = 9;
   localparam int STATUS_W = 2;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic                       done;
      logic signed [VALUE_W-1:0]  removed;
      logic [STATUS_W-1:0]        status;
      logic [LENGTH_W-1:0]        length;
   } pal_rsp_type;

endpackage

@@ sv/pal_mem.sv @@
`timescale 1ns / 1ps

module pal_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic signed [pal_pkg::VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]                  rd_addr,
   output logic signed [pal_pkg::VALUE_W-1:0] rd_data
);

   logic signed [pal_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [pal_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pal_seq.sv @@
`timescale 1ns / 1ps

module pal_seq #(
   parameter int CAPACITY = 256,
   parameter int ADDR_W   = 8,
   parameter int CNT_W    = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               action,
   input  logic signed [pal_pkg::VALUE_W-1:0] value,
   input  logic [pal_pkg::POS_W-1:0]          position,
   input  logic                               rsp_free,
   output logic                               idle,
   output pal_pkg::pal_rsp_type               rsp,
   output logic                               wr_en,
   output logic [ADDR_W-1:0]                  wr_addr,
   output logic signed [pal_pkg::VALUE_W-1:0] wr_data,
   output logic [ADDR_W-1:0]                  rd_addr,
   input  logic signed [pal_pkg::VALUE_W-1:0] rd_data
);

   localparam int CMP_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;

   typedef enum logic [2:0] {
      S_IDLE, S_UP, S_UP_DRAIN, S_PUT, S_DOWN, S_DN_DRAIN, S_FIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic signed [pal_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [ADDR_W-1:0]                  k_ff, k_in;
   logic [ADDR_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic                               pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0]                  pend_idx_ff, pend_idx_in;
   logic signed [pal_pkg::VALUE_W-1:0] removed_ff, removed_in;
   logic [pal_pkg::STATUS_W-1:0]       status_ff, status_in;

   logic [CMP_W-1:0]  pos_e, cnt_e, pos_lo, pos_del;
   logic [ADDR_W-1:0] last_idx;

   assign cnt_e    = CMP_W'(count_ff);
   assign pos_e    = CMP_W'(position);
   assign pos_lo   = (pos_e == '0) ? CMP_W'(1) : pos_e;
   assign pos_del  = (pos_lo > cnt_e) ? cnt_e : pos_lo;
   assign last_idx = ADDR_W'(count_ff - CNT_W'(1));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      value_in    = value_ff;
      k_in        = k_ff;
      rd_idx_in   = rd_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      wr_addr     = pend_idx_ff + ADDR_W'(1);
      wr_data     = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in    = value;
               pend_vld_in = 1'b0;
               removed_in  = '0;
               status_in   = pal_pkg::ST_DONE;
               if (action == pal_pkg::ACT_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = pal_pkg::ST_FULL;
                     state_in  = S_FIN;
                  end else if (pos_lo <= cnt_e) begin
                     k_in      = ADDR_W'(pos_lo - CMP_W'(1));
                     rd_idx_in = last_idx;
                     state_in  = S_UP;
                  end else begin
                     k_in     = ADDR_W'(count_ff);
                     state_in = S_PUT;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = pal_pkg::ST_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     k_in      = ADDR_W'(pos_del - CMP_W'(1));
                     rd_idx_in = ADDR_W'(pos_del - CMP_W'(1));
                     state_in  = S_DOWN;
                  end
               end
            end
         end
         S_UP: begin
            wr_en       = pend_vld_ff;
            pend_vld_in = 1'b1;
            pend_idx_in = rd_idx_ff;
            if (rd_idx_ff == k_ff) begin
               state_in = S_UP_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff - ADDR_W'(1);
            end
         end
         S_UP_DRAIN: begin
            wr_en    = 1'b1;
            state_in = S_PUT;
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff;
            wr_data  = value_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_FIN;
         end
         S_DOWN: begin
            wr_addr     = pend_idx_ff - ADDR_W'(1);
            pend_vld_in = 1'b1;
            pend_idx_in = rd_idx_ff;
            if (pend_vld_ff) begin
               if (pend_idx_ff == k_ff) begin
                  removed_in = rd_data;
               end else begin
                  wr_en = 1'b1;
               end
            end
            if (rd_idx_ff == last_idx) begin
               state_in = S_DN_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + ADDR_W'(1);
            end
         end
         S_DN_DRAIN: begin
            wr_addr = pend_idx_ff - ADDR_W'(1);
            if (pend_idx_ff == k_ff) begin
               removed_in = rd_data;
            end else begin
               wr_en = 1'b1;
            end
            count_in = count_ff - CNT_W'(1);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
      end
      value_ff    <= value_in;
      k_ff        <= k_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
   end

   assign rd_addr     = rd_idx_ff;
   assign idle        = (state_ff == S_IDLE);
   assign rsp.done    = (state_ff == S_FIN);
   assign rsp.removed = removed_ff;
   assign rsp.status  = status_ff;
   assign rsp.length  = pal_pkg::LENGTH_W'(count_ff);

endmodule

@@ sv/positional_array_list.sv @@
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_action, req_value, req_position
// rsp     | out       | rsp_valid/rsp_stall  | rsp_removed_value, rsp_status, rsp_length
//
// one item at a time; an insert or delete moves its stored words one by one through the
// single read and single write port of the list memory (one word per cycle)
// a full insert or empty delete skips the store and goes straight to the finish state
// reset clears the element count, state and valid flag; the store needs no clearing pass
// req_stall is high while an item is in work; a stalled result holds in the output
// register and the next item may be taken meanwhile, finishing once the register frees

module positional_array_list #(
   parameter int CAPACITY = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic signed [pal_pkg::VALUE_W-1:0] req_value,
   input  logic [pal_pkg::POS_W-1:0]          req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [pal_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [pal_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pal_pkg::LENGTH_W-1:0]       rsp_length
);

   // store index and count widths follow the capacity
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic                               seq_idle;
   logic                               rsp_free;
   pal_pkg::pal_rsp_type               seq_rsp;
   logic                               mem_wr_en;
   logic [ADDR_W-1:0]                  mem_wr_addr;
   logic signed [pal_pkg::VALUE_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0]                  mem_rd_addr;
   logic signed [pal_pkg::VALUE_W-1:0] mem_rd_data;

   // output register
   logic                               rsp_valid_ff;
   logic signed [pal_pkg::VALUE_W-1:0] rsp_removed_ff;
   logic [pal_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [pal_pkg::LENGTH_W-1:0]       rsp_length_ff;

   // input side: take an item only when the sequencer sits idle
   assign req_stall = !seq_idle;

   // output register may be loaded when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   pal_seq #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && seq_idle),
      .action   (req_action),
      .value    (req_value),
      .position (req_position),
      .rsp_free (rsp_free),
      .idle     (seq_idle),
      .rsp      (seq_rsp),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_addr  (mem_rd_addr),
      .rd_data  (mem_rd_data)
   );

   // list store: one write and one registered read per cycle
   pal_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result register, loaded as the sequencer finishes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_rsp.done && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (seq_rsp.done && rsp_free) begin
         rsp_removed_ff <= seq_rsp.removed;
         rsp_status_ff  <= seq_rsp.status;
         rsp_length_ff  <= seq_rsp.length;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_length        = rsp_length_ff;

endmodule

@@ sv/pal_chk.sv @@
`timescale 1ns / 1ps

module pal_chk #(
   parameter int CAPACITY = 256
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [pal_pkg::VALUE_W-1:0] rsp_removed_value,
   input logic [pal_pkg::STATUS_W-1:0]       rsp_status,
   input logic [pal_pkg::LENGTH_W-1:0]       rsp_length
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // an accepted item keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting an item");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pal_pkg::ST_EMPTY |-> rsp_length == '0)
      else $error("empty status with nonzero length");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pal_pkg::ST_FULL |->
         rsp_length == pal_pkg::LENGTH_W'(CAPACITY))
      else $error("full status with wrong length");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pal_pkg::ST_DONE |-> rsp_removed_value == '0)
      else $error("nonzero removed word on a rejected item");

endmodule

bind positional_array_list pal_chk #(.CAPACITY(CAPACITY)) u_pal_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_removed_value (rsp_removed_value),
   .rsp_status        (rsp_status),
   .rsp_length        (rsp_length)
);

@@ dv/pal_list_checker.sv @@
`timescale 1ns / 1ps

module pal_list_checker #(
   parameter int CAPACITY = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_action,
   input  logic signed [pal_pkg::VALUE_W-1:0] req_value,
   input  logic [pal_pkg::POS_W-1:0]          req_position,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [pal_pkg::VALUE_W-1:0] rsp_removed_value,
   input  logic [pal_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [pal_pkg::LENGTH_W-1:0]       rsp_length,
   output int                                 fail_count,
   output int                                 pending_results
);

   typedef struct packed {
      logic signed [pal_pkg::VALUE_W-1:0] removed;
      logic [pal_pkg::STATUS_W-1:0]       status;
      logic [pal_pkg::LENGTH_W-1:0]       length;
   } list_result_type;

   // shadow copy of the list
   int                                 shadow_count;
   logic signed [pal_pkg::VALUE_W-1:0] shadow_store [CAPACITY];
   list_result_type                    expected_results [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      shadow_count    = 0;
   end

   function automatic list_result_type apply_list_op(input logic act,
                                       input logic signed [pal_pkg::VALUE_W-1:0] val,
                                       input logic [pal_pkg::POS_W-1:0] pos);
      list_result_type r;
      int              slot;
      int              i;
      r    = '0;
      slot = (pos == 0) ? 1 : int'(pos);
      if (act == pal_pkg::ACT_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            r.status = pal_pkg::ST_FULL;
         end else begin
            if (slot <= shadow_count) begin
               for (i = shadow_count; i > slot - 1; i--)
                  shadow_store[i] = shadow_store[i-1];
               shadow_store[slot-1] = val;
            end else begin
               shadow_store[shadow_count] = val;
            end
            shadow_count++;
            r.status = pal_pkg::ST_DONE;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = pal_pkg::ST_EMPTY;
         end else begin
            if (slot > shadow_count)
               slot = shadow_count;
            r.removed = shadow_store[slot-1];
            for (i = slot - 1; i + 1 < shadow_count; i++)
               shadow_store[i] = shadow_store[i+1];
            shadow_count--;
            r.status = pal_pkg::ST_DONE;
         end
      end
      r.length = shadow_count[pal_pkg::LENGTH_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h",
               $time, field, exp_val, act_val);
   endtask

   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         shadow_count = 0;
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(apply_list_op(req_action, req_value, req_position));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected result, expected none, actual 0x%h/%0d/%0d",
                        $time, rsp_removed_value, rsp_status, rsp_length);
            end else begin
               want = expected_results.pop_front();
               if (rsp_removed_value !== want.removed)
                  report_mismatch("removed_value", want.removed, rsp_removed_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_length !== want.length)
                  report_mismatch("length", 32'(want.length), 32'(rsp_length));
            end
         end
      end
      pending_results = expected_results.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int CAPACITY    = 256;
   localparam int RANDOM_ITEMS = 1650;
   // slowest legal run is roughly 1700 items of a full shift each; allow several times that
   localparam int CYCLE_LIMIT = 2_000_000;

   localparam logic signed [pal_pkg::VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [pal_pkg::VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   // stimulus bias: grow the list to full, drain it to empty, or wander
   typedef enum logic [1:0] {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} list_bias_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_action = pal_pkg::ACT_INSERT;
   logic signed [pal_pkg::VALUE_W-1:0]   req_value = '0;
   logic [pal_pkg::POS_W-1:0]            req_position = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [pal_pkg::VALUE_W-1:0]   rsp_removed_value;
   logic [pal_pkg::STATUS_W-1:0]         rsp_status;
   logic [pal_pkg::LENGTH_W-1:0]         rsp_length;

   int fail_count;
   int pending_results;

   // quiet: neither side idles while this is set
   bit quiet = 1'b0;
   int cycle_count = 0;

   // rough length as seen by the sender, only for steering the stimulus
   int sent_length = 0;
   int n_inserts = 0;
   int n_deletes = 0;
   int n_full_hits = 0;
   int n_empty_hits = 0;
   int n_full_fills = 0;

   positional_array_list #(.CAPACITY(CAPACITY)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length)
   );

   pal_list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results);
         $display("tb NOT OK");
         $finish;
      end
   end

   // receiver back-pressure, about one cycle in five outside the quiet stretch
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 20);
   end

   // one item onto the request channel; returns at the edge that accepts it
   task automatic send_item(input logic act, input logic signed [pal_pkg::VALUE_W-1:0] val,
                            input logic [pal_pkg::POS_W-1:0] pos);
      @(negedge clock);
      // random gaps before the item, valid held low meanwhile
      while (!quiet && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_value    <= val;
      req_position <= pos;
      // sampled before the edge updates, so the handshake seen is the one the block sees
      do @(posedge clock); while (req_stall);
      // keep the steering length in step with what the list should now hold
      if (act == pal_pkg::ACT_INSERT) begin
         n_inserts++;
         if (sent_length >= CAPACITY) begin
            n_full_hits++;
         end else begin
            sent_length++;
            if (sent_length == CAPACITY)
               n_full_fills++;
         end
      end else begin
         n_deletes++;
         if (sent_length == 0)
            n_empty_hits++;
         else
            sent_length--;
      end
   endtask

   // sender holds off until every outstanding result has come back
   task automatic wait_for_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
   endtask

   function automatic logic signed [pal_pkg::VALUE_W-1:0] pick_value;
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return INT_MIN;
      else if (roll < 16)
         return INT_MAX;
      else if (roll < 20)
         return '0;
      else if (roll < 24)
         return -1;
      return $urandom;
   endfunction

   // positions cluster on the interesting spots: zero, front, last, just past the end
   function automatic logic [pal_pkg::POS_W-1:0] pick_position(input int cur_len);
      int roll;
      int p;
      roll = $urandom_range(99);
      if (roll < 10)
         p = 0;
      else if (roll < 20)
         p = 1;
      else if (roll < 30)
         p = cur_len;
      else if (roll < 40)
         p = (cur_len + 1 > 511) ? 511 : cur_len + 1;
      else if (roll < 50)
         p = $urandom_range(511);
      else
         p = $urandom_range((cur_len < 1) ? 1 : cur_len, 1);
      return p[pal_pkg::POS_W-1:0];
   endfunction

   initial begin : stimulus
      list_bias_type bias;
      int            settle;
      int            mixed_left;
      int            insert_pct;
      logic          act;
      int            n;

      bias       = BIAS_GROW;
      settle     = 0;
      mixed_left = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty deletes, extremes of value and position, front/middle/end cases
      send_item(pal_pkg::ACT_DELETE, '0, 9'd0);          // delete on empty, position zero
      send_item(pal_pkg::ACT_DELETE, '0, 9'd511);        // delete on empty, highest position
      send_item(pal_pkg::ACT_INSERT, INT_MIN, 9'd0);     // position zero taken as front
      send_item(pal_pkg::ACT_INSERT, INT_MAX, 9'd511);   // past end, appended
      send_item(pal_pkg::ACT_INSERT, -1, 9'd1);          // at the front
      send_item(pal_pkg::ACT_INSERT, '0, 9'd2);          // into the middle
      send_item(pal_pkg::ACT_INSERT, 32'sh5A5A_A5A5, 9'd4);  // just before the last
      send_item(pal_pkg::ACT_INSERT, 32'shA5A5_5A5A, 9'd6);  // one past the end
      send_item(pal_pkg::ACT_INSERT, 32'sh0000_0001, 9'd256);
      send_item(pal_pkg::ACT_DELETE, 32'sh1234_5678, 9'd0);  // value ignored, front removed
      send_item(pal_pkg::ACT_DELETE, '0, 9'd511);        // past end, last removed
      send_item(pal_pkg::ACT_DELETE, '0, 9'd2);          // middle
      send_item(pal_pkg::ACT_DELETE, '0, 9'd256);
      send_item(pal_pkg::ACT_DELETE, '0, 9'd1);
      send_item(pal_pkg::ACT_DELETE, '0, 9'd1);
      send_item(pal_pkg::ACT_DELETE, '0, 9'd0);          // last element out
      send_item(pal_pkg::ACT_DELETE, -1, 9'd3);          // empty again
      send_item(pal_pkg::ACT_INSERT, INT_MAX, 9'd0);
      send_item(pal_pkg::ACT_DELETE, '0, 9'd1);

      // let the block go fully quiet before the random part
      wait_for_results();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // a long stretch with no idling on either side
         quiet = (n >= 600 && n < 900);
         // pause mid-run until everything outstanding has returned
         if (n == 300 || n == 1200)
            wait_for_results();

         // bias moves on once the list has sat at full or empty for five items; mixed runs 150 items
         case (bias)
            BIAS_GROW: begin
               insert_pct = 85;
               if (sent_length >= CAPACITY) settle++;
               if (settle >= 5) begin
                  bias   = BIAS_SHRINK;
                  settle = 0;
               end
            end
            BIAS_SHRINK: begin
               insert_pct = 15;
               if (sent_length == 0) settle++;
               if (settle >= 5) begin
                  bias       = BIAS_MIXED;
                  settle     = 0;
                  mixed_left = 150;
               end
            end
            default: begin
               insert_pct = 50;
               mixed_left--;
               if (mixed_left <= 0)
                  bias = BIAS_GROW;
            end
         endcase

         act = ($urandom_range(99) < insert_pct) ? pal_pkg::ACT_INSERT : pal_pkg::ACT_DELETE;
         send_item(act, pick_value(), pick_position(sent_length));
      end

      quiet = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then a short tail to catch any stray result
      while (pending_results != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d inserts and %0d deletes; list filled to capacity %0d times",
               n_inserts, n_deletes, n_full_fills);
      $display("inserts refused as full: %0d, deletes on an empty list: %0d, failures: %0d",
               n_full_hits, n_empty_hits, fail_count);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
